### hdl/flag_run_deframer_rle_expander_defines.svh
// Assertion macros for the flag-run deframer.
// Used by the checker; needs clk and rst in the scope of each use.
`ifndef FLAG_RUN_DEFRAMER_RLE_EXPANDER_DEFINES_SVH
`define FLAG_RUN_DEFRAMER_RLE_EXPANDER_DEFINES_SVH

// Same-cycle implication
`define FRDRLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FRDRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/frdrle_pkg.sv
// Shared types, codes and helpers of the flag-run deframer.
// No dependencies.
package frdrle_pkg;

  typedef logic [1:0] status_t;
  typedef logic [3:0] run_t;
  typedef logic [0:0] cfg_index_t;

  localparam status_t STATUS_DATA        = 2'd0;
  localparam status_t STATUS_PAYLOAD_OVF = 2'd1;
  localparam status_t STATUS_EXPAND_OVF  = 2'd2;

  localparam cfg_index_t REG_HEADER = 1'b0;
  localparam cfg_index_t REG_FOOTER = 1'b1;

  localparam logic [7:0] HEADER_RESET = 8'hFF;
  localparam logic [7:0] FOOTER_RESET = 8'hFE;

  localparam run_t RUN_FIRE = 4'd8;
  localparam run_t RUN_SAT  = 4'd15;
  localparam int   FOOTER_TAIL = 7;

  // Frame-close command to the expander; plen is below REQUEST_SIZE unless ovf
  typedef struct packed {
    logic [1:0] ch;
    logic [7:0] plen;
    logic       ovf;
  } expand_cmd_t;

  function automatic run_t run_next(run_t run, logic hit);
    if (!hit) return '0;
    return (run < RUN_SAT) ? run + run_t'(1) : RUN_SAT;
  endfunction

endpackage

### hdl/flag_run_deframer_rle_expander.sv
// Flag-run deframer with run-length expansion, top level.
// Byte path: an in-range item stalls the input for its read-modify-write of control
// memory. Frame close: payload check per pair, then REQUEST_SIZE results at one per
// cycle unless stalled, between capture-store pair fetches; or one error result.
// Reset: control-memory valid bits clear at once (all channels free, counters zero),
// registers return to 0xFF / 0xFE; the capture store is not cleared.
module flag_run_deframer_rle_expander #(
  parameter int CHANNELS      = 4,
  parameter int REQUEST_SIZE  = 32,
  parameter int CAPTURE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             channel,
  input  logic [7:0]             data_byte,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [1:0]             out_channel,
  output logic [7:0]             out_byte,
  output frdrle_pkg::status_t    status,
  output logic                   last,
  input  logic                   cfg_write,
  input  frdrle_pkg::cfg_index_t cfg_index,
  input  logic [7:0]             cfg_data
);
  import frdrle_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CAPTURE_DEPTH + 2);
  localparam int CAP_AW = $clog2(CHANNELS * CAPTURE_DEPTH);

  typedef struct packed {
    run_t             hr;
    run_t             fr;
    logic             cap;
    logic [CNT_W-1:0] cnt;
  } chan_state_t;

  localparam int CS_W = $bits(chan_state_t);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_EXPAND} state_t;

  state_t      state;
  logic [1:0]  ch_q;
  logic [7:0]  byte_q;
  logic [7:0]  header_byte;
  logic [7:0]  footer_byte;

  logic        accept;
  logic        in_range;
  logic [CS_W-1:0] cs_rdata;
  chan_state_t cur;
  chan_state_t nxt;
  run_t        hr_n;
  run_t        fr_n;
  logic        hfire;
  logic        close;
  logic        lost;
  logic [CNT_W-1:0] plen;
  logic        cap_we;
  logic [CAP_AW-1:0] cap_waddr;
  logic [CAP_AW-1:0] cap_raddr;
  logic [7:0]  cap_rdata;
  logic        exp_start;
  logic        exp_busy;
  expand_cmd_t cmd;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_range   = 5'(channel) < 5'(CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      footer_byte <= FOOTER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER: header_byte <= cfg_data;
        REG_FOOTER: footer_byte <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          // out-of-range channels are dropped without a state change
          if (accept && in_range) begin
            ch_q   <= channel;
            byte_q <= data_byte;
            state  <= S_RMW;
          end
        end
        S_RMW:    state <= close ? S_EXPAND : S_IDLE;
        S_EXPAND: if (!exp_busy) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cur    = chan_state_t'(cs_rdata);
    nxt    = cur;
    hr_n   = run_next(cur.hr, byte_q == header_byte);
    fr_n   = run_next(cur.fr, byte_q == footer_byte);
    hfire  = (hr_n == RUN_FIRE);
    close  = !hfire && (fr_n == RUN_FIRE) && cur.cap;
    cap_we = 1'b0;
    if (hfire) begin
      nxt.hr  = '0;
      nxt.fr  = fr_n;
      nxt.cap = 1'b1;
      nxt.cnt = '0;
    end else if (close) begin
      nxt = '0;
    end else begin
      nxt.hr = hr_n;
      nxt.fr = fr_n;
      if (cur.cap) begin
        cap_we = (state == S_RMW) && (cur.cnt < CNT_W'(CAPTURE_DEPTH));
        // count stops one past the depth: frame marked lost
        if (cur.cnt <= CNT_W'(CAPTURE_DEPTH)) begin
          nxt.cnt = cur.cnt + CNT_W'(1);
        end
      end
    end
    lost = cur.cnt > CNT_W'(CAPTURE_DEPTH);
    plen = (cur.cnt >= CNT_W'(FOOTER_TAIL)) ? cur.cnt - CNT_W'(FOOTER_TAIL) : '0;
    cmd.ch   = ch_q;
    cmd.plen = 8'(plen);
    cmd.ovf  = lost || (10'(plen) >= 10'(REQUEST_SIZE));
    exp_start = (state == S_RMW) && close;
  end

  assign cap_waddr = CAP_AW'(CH_W'(ch_q)) * CAP_AW'(CAPTURE_DEPTH) + CAP_AW'(cur.cnt);

  // Read at accept, write back in the following cycle; the next read of any
  // entry comes no earlier than the cycle after, so no forwarding is needed.
  frdrle_chan_mem #(
    .DEPTH(CHANNELS),
    .AW   (CH_W),
    .WIDTH(CS_W)
  ) u_chan_mem (
    .clk  (clk),
    .rst  (rst),
    .re   (accept && in_range),
    .raddr(CH_W'(channel)),
    .we   (state == S_RMW),
    .waddr(CH_W'(ch_q)),
    .wdata(nxt),
    .rdata(cs_rdata)
  );

  frdrle_capture_mem #(
    .DEPTH(CHANNELS * CAPTURE_DEPTH),
    .AW   (CAP_AW)
  ) u_capture_mem (
    .clk  (clk),
    .we   (cap_we),
    .waddr(cap_waddr),
    .wdata(byte_q),
    .raddr(cap_raddr),
    .rdata(cap_rdata)
  );

  frdrle_expand #(
    .CHANNELS     (CHANNELS),
    .REQUEST_SIZE (REQUEST_SIZE),
    .CAPTURE_DEPTH(CAPTURE_DEPTH),
    .CAP_AW       (CAP_AW)
  ) u_expand (
    .clk         (clk),
    .rst         (rst),
    .start       (exp_start),
    .cmd         (cmd),
    .busy        (exp_busy),
    .rd_addr     (cap_raddr),
    .rd_data     (cap_rdata),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_channel (out_channel),
    .out_byte    (out_byte),
    .status      (status),
    .last        (last)
  );

endmodule

### hdl/frdrle_chan_mem.sv
// Per-channel control state memory, registered read.
// Valid bit per entry; an entry never written reads as zero. No package use.
module frdrle_chan_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_raw;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_raw : '0;

endmodule

### hdl/frdrle_capture_mem.sv
// Capture byte store for all channels, one write and one read port.
// Read data registered; contents undefined until written. No package use.
module frdrle_capture_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/frdrle_expand.sv
// Frame-close sequencer: checks the run-length payload, then emits the request,
// or a single error result. Reads the capture store; uses frdrle_pkg.
module frdrle_expand #(
  parameter int CHANNELS      = 4,
  parameter int REQUEST_SIZE  = 32,
  parameter int CAPTURE_DEPTH = 64,
  parameter int CAP_AW        = $clog2(CHANNELS * CAPTURE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  frdrle_pkg::expand_cmd_t cmd,
  output logic                  busy,
  output logic [CAP_AW-1:0]     rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [1:0]            out_channel,
  output logic [7:0]            out_byte,
  output frdrle_pkg::status_t   status,
  output logic                  last
);
  import frdrle_pkg::*;

  localparam int N_W = $clog2(REQUEST_SIZE + 1);

  typedef enum logic [3:0] {
    E_IDLE, E_SCAN_RD, E_SCAN_CHK, E_FETCH_C, E_WAIT_C, E_WAIT_V, E_EMIT, E_PAD, E_ERR
  } estate_t;

  estate_t           state;
  logic [1:0]        ch_q;
  logic [7:0]        plen;
  logic [CAP_AW-1:0] base;
  logic [7:0]        idx;
  logic [N_W-1:0]    n;
  logic [N_W-1:0]    k;
  logic [7:0]        rem;
  logic [7:0]        val;
  status_t           err;

  logic       pair_avail;
  logic       slot_free;
  logic       last_k;
  logic [8:0] room;

  assign pair_avail = (9'(idx) + 9'd1) < 9'(plen);
  assign slot_free  = !result_valid || !result_stall;
  assign last_k     = (k == N_W'(REQUEST_SIZE - 1));
  assign room       = 9'(REQUEST_SIZE) - 9'(n);
  assign busy       = (state != E_IDLE);
  // count byte at idx, value byte right after it
  assign rd_addr    = base + CAP_AW'(idx) + CAP_AW'(state == E_WAIT_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= E_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        E_IDLE: begin
          if (start) begin
            ch_q <= cmd.ch;
            plen <= cmd.plen;
            base <= CAP_AW'(cmd.ch) * CAP_AW'(CAPTURE_DEPTH);
            idx  <= '0;
            n    <= '0;
            k    <= '0;
            if (cmd.ovf) begin
              err   <= STATUS_PAYLOAD_OVF;
              state <= E_ERR;
            end else begin
              state <= E_SCAN_RD;
            end
          end
        end
        E_SCAN_RD: begin
          if (pair_avail) begin
            state <= E_SCAN_CHK;
          end else begin
            idx   <= '0;
            state <= E_FETCH_C;
          end
        end
        E_SCAN_CHK: begin
          if (rd_data == 8'd0) begin
            idx   <= '0;
            state <= E_FETCH_C;
          end else if ({1'b0, rd_data} > room) begin
            err   <= STATUS_EXPAND_OVF;
            state <= E_ERR;
          end else begin
            n     <= n + N_W'(rd_data);
            idx   <= idx + 8'd2;
            state <= E_SCAN_RD;
          end
        end
        E_FETCH_C: begin
          state <= pair_avail ? E_WAIT_C : E_PAD;
        end
        E_WAIT_C: begin
          if (rd_data == 8'd0) begin
            state <= E_PAD;
          end else begin
            rem   <= rd_data;
            state <= E_WAIT_V;
          end
        end
        E_WAIT_V: begin
          val   <= rd_data;
          state <= E_EMIT;
        end
        E_EMIT: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            out_channel  <= ch_q;
            out_byte     <= val;
            status       <= STATUS_DATA;
            last         <= last_k;
            k            <= k + N_W'(1);
            rem          <= rem - 8'd1;
            if (last_k) begin
              state <= E_IDLE;
            end else if (rem == 8'd1) begin
              idx   <= idx + 8'd2;
              state <= E_FETCH_C;
            end
          end
        end
        E_PAD: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            out_channel  <= ch_q;
            out_byte     <= 8'd0;
            status       <= STATUS_DATA;
            last         <= last_k;
            k            <= k + N_W'(1);
            if (last_k) begin
              state <= E_IDLE;
            end
          end
        end
        E_ERR: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            out_channel  <= ch_q;
            out_byte     <= 8'd0;
            status       <= err;
            last         <= 1'b1;
            state        <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

### hdl/frdrle_checker.sv
// Port-level checks of the flag-run deframer, bound to the top level.
// Uses frdrle_pkg and the assertion macros header.
`include "flag_run_deframer_rle_expander_defines.svh"

module frdrle_checker #(
  parameter int CHANNELS = 4
) (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic [1:0]          channel,
  input logic                result_valid,
  input logic                result_stall,
  input logic [7:0]          out_byte,
  input frdrle_pkg::status_t status,
  input logic                last
);
  import frdrle_pkg::*;

  `FRDRLE_ASSERT_NOW(a_status_code, result_valid, (status == STATUS_DATA) || (status == STATUS_PAYLOAD_OVF) || (status == STATUS_EXPAND_OVF), "undefined status code")

  // error results close the frame and carry no byte
  `FRDRLE_ASSERT_NOW(a_error_result, result_valid && (status != STATUS_DATA), last && (out_byte == 8'd0), "error result without last or with data")

  `FRDRLE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(out_byte) && $stable(status) && $stable(last), "stalled result changed")

  // a byte for a live channel blocks the input for its update cycle
  `FRDRLE_ASSERT_NEXT(a_one_item, item_valid && !item_stall && (5'(channel) < 5'(CHANNELS)), item_stall, "second transfer during channel update")

endmodule

bind flag_run_deframer_rle_expander frdrle_checker #(.CHANNELS(CHANNELS)) u_frdrle_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .channel     (channel),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .out_byte    (out_byte),
  .status      (status),
  .last        (last)
);

### dv/tb_flag_run_deframer_rle_expander.sv
// Testbench for flag_run_deframer_rle_expander: directed frame table, then random
// interleaved frames under several flag settings, checked by an in-bench frame decoder.
// Depends on hdl/frdrle_pkg.sv and the top-level RTL.
`timescale 1ns / 1ps

module tb_flag_run_deframer_rle_expander;
  import frdrle_pkg::*;

  localparam int NCH       = 4;
  localparam int REQ_SIZE  = 32;
  localparam int CAP_DEPTH = 64;
  localparam int SETTLE    = 200;
  localparam int LONG_HOLD = 400;
  localparam int DIR_ROWS  = 35;

  typedef struct packed {
    logic [1:0] ch;
    logic [7:0] data;
    status_t    st;
    logic       fin;
  } frame_res_t;

  // one table row is a run of identical bytes; n_typed > 0 types the close outcome
  typedef struct packed {
    logic [1:0] ch;
    logic [7:0] data;
    logic [7:0] reps;
    logic [5:0] n_typed;
    logic [7:0] t_byte;
    status_t    t_st;
  } dir_row_t;

  typedef enum int {FR_PLAIN, FR_WIDE, FR_LONG, FR_LOST, FR_NOISE} frame_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] channel = '0;
  logic [7:0] data_byte = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] out_channel;
  logic [7:0] out_byte;
  status_t    status;
  logic       last;
  logic       cfg_write = 1'b0;
  cfg_index_t cfg_index = REG_HEADER;
  logic [7:0] cfg_data = '0;

  // decoder state
  logic [7:0] hdr_val;
  logic [7:0] ftr_val;
  run_t       hdr_run [NCH];
  run_t       ftr_run [NCH];
  bit         capt_on [NCH];
  int         cap_cnt [NCH];
  logic [7:0] cap_mem [NCH][CAP_DEPTH];

  frame_res_t predicted_q [$];
  frame_res_t expected_q [$];
  logic [7:0] lane_q [NCH][$];

  int mism_cnt   = 0;
  int items_sent = 0;
  int res_seen   = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{2'd0, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'hFE, 8'd8,  6'd32, 8'h00, STATUS_DATA},       // empty payload, all padding
    '{2'd1, 8'hFE, 8'd8,  6'd0,  8'h00, STATUS_DATA},       // footer run while free
    '{2'd1, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h03, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h00, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h02, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'hFF, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h01, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h80, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h05, 8'd1,  6'd0,  8'h00, STATUS_DATA},       // dangling count byte
    '{2'd1, 8'hFE, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd2, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd2, 8'h01, 8'd32, 6'd0,  8'h00, STATUS_DATA},       // payload exactly REQ_SIZE
    '{2'd2, 8'hFE, 8'd8,  6'd1,  8'h00, STATUS_PAYLOAD_OVF},
    '{2'd3, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd3, 8'h20, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd3, 8'h5A, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd3, 8'h01, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd3, 8'h77, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd3, 8'hFE, 8'd8,  6'd1,  8'h00, STATUS_EXPAND_OVF},
    '{2'd0, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'h02, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'h11, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'h00, 8'd1,  6'd0,  8'h00, STATUS_DATA},       // zero count ends decode
    '{2'd0, 8'h33, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'h04, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'h44, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd0, 8'hFE, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'h7F, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'hFF, 8'd8,  6'd0,  8'h00, STATUS_DATA},       // header run restarts capture
    '{2'd1, 8'h20, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'hC3, 8'd1,  6'd0,  8'h00, STATUS_DATA},
    '{2'd1, 8'hFE, 8'd8,  6'd0,  8'h00, STATUS_DATA}        // expands to exactly REQ_SIZE
  };

  flag_run_deframer_rle_expander #(
    .CHANNELS     (NCH),
    .REQUEST_SIZE (REQ_SIZE),
    .CAPTURE_DEPTH(CAP_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .channel     (channel),
    .data_byte   (data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_channel (out_channel),
    .out_byte    (out_byte),
    .status      (status),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what);
    mism_cnt++;
    if (mism_cnt <= 30) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Decode one accepted byte; any results of a frame close go to predicted_q.
  function automatic void deframe_predict(input logic [1:0] ch, input logic [7:0] b);
    int cnt, plen, n, i, k, c;
    logic [7:0] req [REQ_SIZE];
    if (b == hdr_val) hdr_run[ch] = (hdr_run[ch] == RUN_SAT) ? RUN_SAT : hdr_run[ch] + 1'b1;
    else hdr_run[ch] = '0;
    if (b == ftr_val) ftr_run[ch] = (ftr_run[ch] == RUN_SAT) ? RUN_SAT : ftr_run[ch] + 1'b1;
    else ftr_run[ch] = '0;

    if (hdr_run[ch] == RUN_FIRE) begin
      capt_on[ch] = 1'b1;
      hdr_run[ch] = '0;
      cap_cnt[ch] = 0;
      return;
    end
    if (!(ftr_run[ch] == RUN_FIRE && capt_on[ch])) begin
      if (capt_on[ch]) begin
        if (cap_cnt[ch] < CAP_DEPTH) cap_mem[ch][cap_cnt[ch]] = b;
        if (cap_cnt[ch] <= CAP_DEPTH) cap_cnt[ch]++;
      end
      return;
    end

    cnt = cap_cnt[ch];
    plen = (cnt >= FOOTER_TAIL) ? cnt - FOOTER_TAIL : 0;
    capt_on[ch] = 1'b0;
    hdr_run[ch] = '0;
    ftr_run[ch] = '0;
    cap_cnt[ch] = 0;
    if (cnt > CAP_DEPTH || plen >= REQ_SIZE) begin
      predicted_q.push_back('{ch, 8'h00, STATUS_PAYLOAD_OVF, 1'b1});
      return;
    end
    for (k = 0; k < REQ_SIZE; k++) req[k] = 8'h00;
    n = 0;
    for (i = 0; i + 1 < plen; i += 2) begin
      c = cap_mem[ch][i];
      if (c == 0) break;
      if (c > REQ_SIZE - n) begin
        predicted_q.push_back('{ch, 8'h00, STATUS_EXPAND_OVF, 1'b1});
        return;
      end
      for (k = 0; k < c; k++) begin
        req[n] = cap_mem[ch][i + 1];
        n++;
      end
    end
    for (k = 0; k < REQ_SIZE; k++)
      predicted_q.push_back('{ch, req[k], STATUS_DATA, k == REQ_SIZE - 1});
  endfunction

  task automatic send_byte(input logic [1:0] ch, input logic [7:0] b, input int n_typed,
                           input logic [7:0] t_byte, input status_t t_st);
    int gap, k;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    channel    <= ch;
    data_byte  <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    deframe_predict(ch, b);
    if (n_typed > 0) begin
      predicted_q.delete();
      for (k = 0; k < n_typed; k++)
        expected_q.push_back('{ch, t_byte, t_st, k == n_typed - 1});
    end else begin
      while (predicted_q.size() > 0) expected_q.push_back(predicted_q.pop_front());
    end
  endtask

  // input idle, all results in, then time for any work that yields nothing
  task automatic drain_idle();
    item_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_flags(input logic [7:0] h, input logic [7:0] f);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_HEADER;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_FOOTER;
    cfg_data  <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
    hdr_val = h;
    ftr_val = f;
  endtask

  task automatic add_run(input int ch, input logic [7:0] v, input int len);
    int k;
    for (k = 0; k < len; k++) lane_q[ch].push_back(v);
  endtask

  task automatic queue_frame(input int ch, input frame_kind_t kind);
    int len, k, r;
    logic [7:0] v;
    if (kind == FR_NOISE) begin
      len = $urandom_range(1, 4);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 2);
        v = (r == 0) ? hdr_val : (r == 1) ? ftr_val : 8'($urandom_range(0, 255));
        add_run(ch, v, $urandom_range(1, 7));
      end
      return;
    end
    add_run(ch, hdr_val, 8);
    case (kind)
      FR_LONG: begin
        len = $urandom_range(REQ_SIZE - 2, REQ_SIZE + 12);
        for (k = 0; k < len; k++) lane_q[ch].push_back(8'($urandom_range(0, 255)));
      end
      FR_LOST: begin
        len = $urandom_range(CAP_DEPTH - 8, CAP_DEPTH + 4);
        for (k = 0; k < len; k++) lane_q[ch].push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        len = $urandom_range(0, 8);
        for (k = 0; k < len; k++) begin
          if (kind == FR_WIDE) v = 8'($urandom_range(0, 255));
          else if ($urandom_range(0, 9) == 0) v = 8'h00;
          else v = 8'($urandom_range(1, 5));
          lane_q[ch].push_back(v);
          lane_q[ch].push_back(8'($urandom_range(0, 255)));
          // partial footer run inside the payload is just data
          if ($urandom_range(0, 19) == 0) add_run(ch, ftr_val, 7);
        end
        if ($urandom_range(0, 2) == 0) lane_q[ch].push_back(8'($urandom_range(0, 255)));
      end
    endcase
    // some frames are left open and get restarted by a later header run
    if ($urandom_range(0, 9) != 0) add_run(ch, ftr_val, 8);
  endtask

  task automatic random_phase(input int budget, input bit force_lost);
    int first, n, k, ch, r, pending;
    frame_kind_t kind;
    first = items_sent;
    while (items_sent - first < budget) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        ch = $urandom_range(0, NCH - 1);
        r = $urandom_range(0, 99);
        if (force_lost)  kind = FR_LOST;
        else if (r < 6)  kind = FR_LOST;
        else if (r < 16) kind = FR_LONG;
        else if (r < 30) kind = FR_WIDE;
        else if (r < 42) kind = FR_NOISE;
        else             kind = FR_PLAIN;
        force_lost = 1'b0;
        queue_frame(ch, kind);
      end
      // interleave the lanes; per-channel order is kept
      forever begin
        pending = 0;
        for (k = 0; k < NCH; k++) pending += lane_q[k].size();
        if (pending == 0) break;
        do ch = $urandom_range(0, NCH - 1); while (lane_q[ch].size() == 0);
        send_byte(2'(ch), lane_q[ch].pop_front(), 0, 8'h00, STATUS_DATA);
      end
    end
  endtask

  // result side: random stall, with one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        result_stall <= !calm && ($urandom_range(0, 2) == 0);
        repeat (1 + pick_gap()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    frame_res_t want;
    if (!rst && result_valid && !result_stall) begin
      res_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d with nothing expected (ch %0d byte %h st %0d)",
                         res_seen, out_channel, out_byte, status));
      end else begin
        want = expected_q.pop_front();
        if (out_channel !== want.ch)
          report($sformatf("result %0d out_channel %0d want %0d", res_seen, out_channel,
                           want.ch));
        if (out_byte !== want.data)
          report($sformatf("result %0d out_byte %h want %h", res_seen, out_byte, want.data));
        if (status !== want.st)
          report($sformatf("result %0d status %0d want %0d", res_seen, status, want.st));
        if (last !== want.fin)
          report($sformatf("result %0d last %b want %b", res_seen, last, want.fin));
      end
    end
  end

  initial begin
    int r, k;
    hdr_val = HEADER_RESET;
    ftr_val = FOOTER_RESET;
    for (k = 0; k < NCH; k++) begin
      hdr_run[k] = '0;
      ftr_run[k] = '0;
      capt_on[k] = 1'b0;
      cap_cnt[k] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++)
      for (k = 0; k < dir_tab[r].reps; k++)
        send_byte(dir_tab[r].ch, dir_tab[r].data,
                  (k == dir_tab[r].reps - 1) ? int'(dir_tab[r].n_typed) : 0,
                  dir_tab[r].t_byte, dir_tab[r].t_st);

    drain_idle();
    set_flags(8'h00, 8'hFF);
    hold_req = 1'b1;
    random_phase(40, 1'b1);

    drain_idle();
    set_flags(8'hFF, 8'h00);
    calm = 1'b1;
    random_phase(30, 1'b0);
    calm = 1'b0;

    // same flag byte for both: the header run always wins
    drain_idle();
    set_flags(8'hA5, 8'hA5);
    random_phase(16, 1'b0);

    drain_idle();
    set_flags(8'h3C, 8'hC3);
    random_phase(40, 1'b0);

    drain_idle();
    set_flags(8'h7E, 8'h7D);
    random_phase(30, 1'b0);

    drain_idle();
    if (mism_cnt == 0) begin
      $display("flag_run_deframer_rle_expander: match");
    end else begin
      $display("flag_run_deframer_rle_expander: mismatch");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TIMEOUT: %0d results still expected", expected_q.size());
    $display("flag_run_deframer_rle_expander: mismatch");
    $finish;
  end

endmodule

### flag_run_deframer_rle_expander.f
+incdir+hdl
hdl/frdrle_pkg.sv
hdl/frdrle_chan_mem.sv
hdl/frdrle_capture_mem.sv
hdl/frdrle_expand.sv
hdl/flag_run_deframer_rle_expander.sv
hdl/frdrle_checker.sv
dv/tb_flag_run_deframer_rle_expander.sv
